>>> sv/sgl_pkg.sv
package sgl_pkg;

	typedef logic [3:0] step_t;

	localparam step_t S_IDLE   = 4'd0;
	localparam step_t S_CHKZ   = 4'd1;
	localparam step_t S_HALVE2 = 4'd2;
	localparam step_t S_HALVEX = 4'd3;
	localparam step_t S_HALVEY = 4'd4;
	localparam step_t S_SUB    = 4'd5;
	localparam step_t S_TESTY  = 4'd6;
	localparam step_t S_GSHIFT = 4'd7;
	localparam step_t S_DIV    = 4'd8;
	localparam step_t S_MULI   = 4'd9;
	localparam step_t S_MUL    = 4'd10;
	localparam step_t S_OWAIT  = 4'd11;
	localparam step_t S_FINISH = 4'd12;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_HALVE_XY,
		OP_HALVE_X,
		OP_HALVE_Y,
		OP_SUBSWAP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_MUL_INIT,
		OP_MUL_STEP,
		OP_FINISH
	} op_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_IN_TXN,
		C_ZERO,
		C_BOTH_EVEN,
		C_X_EVEN,
		C_Y_EVEN,
		C_Y_NZ,
		C_CNT_RUN,
		C_OUT_FULL
	} cond_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef struct packed {
		cond_t cond;
		op_t   op;
		step_t tgt_t;
		step_t tgt_f;
	} uword_t;

	typedef struct packed {
		logic zero;
		logic both_even;
		logic x_even;
		logic y_even;
		logic y_nz;
		logic cnt_run;
	} dp_flags_t;

endpackage

>>> sv/sgl_ifs.sv
interface sgl_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] operand_a;
	logic signed [DATA_WIDTH-1:0] operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface sgl_out_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic        [DATA_WIDTH-2:0] divisor_out;
	logic signed [DATA_WIDTH-1:0] multiple_out;
	sgl_pkg::status_t             status;

	modport source (output valid, output divisor_out, output multiple_out, output status,
		input ready);
	modport sink (input valid, input divisor_out, input multiple_out, input status,
		output ready);
endinterface

>>> sv/signed_gcd_lcm_unit.sv
// Signed gcd / lcm unit.
// operands (sink): operand_a, operand_b, signed DATA_WIDTH bits.
// results (source): divisor_out = gcd(|a|,|b|), multiple_out = lcm(|a|,|b|),
// negated when either operand is negative, status ok / zero operand / overflow.
// On a zero operand or an lcm above 2^(DATA_WIDTH-1)-1 both values are zero.
// One transaction in gives one transaction out. A microcode sequencer steps a
// single datapath: binary gcd, restoring divide of |a| by the gcd, and
// shift-add multiply by |b|, one bit per cycle.
// A zero operand goes from the zero check straight to the output wait step;
// otherwise the gcd loop halves both values while both are even, then x, then
// y, and subtracts until y is zero, before the divide and multiply. One
// transaction is worked at a time; the next can be accepted once the previous
// result is written.
// A new transaction is accepted while the previous result still waits.
// If the receiver stalls, the next result holds in the wait step until the
// output register is taken. Reset returns to idle with no result pending.
module signed_gcd_lcm_unit #(
	parameter int DATA_WIDTH = 32
) (
	input logic      clk,
	input logic      arst_n,
	sgl_in_if.sink   operands,
	sgl_out_if.source results
);
	import sgl_pkg::*;

	step_t     pc_q, pc_next;
	uword_t    ctl;
	dp_flags_t flags;
	op_t       dp_op;
	logic      cond_true, ov_q;

	sgl_rom u_rom (
		.pc  (pc_q),
		.ctl (ctl)
	);

	assign operands.ready = pc_q == S_IDLE;

	always_comb begin
		unique case (ctl.cond)
			C_ALWAYS:    cond_true = 1'b1;
			C_IN_TXN:    cond_true = operands.valid && operands.ready;
			C_ZERO:      cond_true = flags.zero;
			C_BOTH_EVEN: cond_true = flags.both_even;
			C_X_EVEN:    cond_true = flags.x_even;
			C_Y_EVEN:    cond_true = flags.y_even;
			C_Y_NZ:      cond_true = flags.y_nz;
			C_CNT_RUN:   cond_true = flags.cnt_run;
			C_OUT_FULL:  cond_true = ov_q && !results.ready;
			default:     cond_true = 1'b0;
		endcase
		pc_next = cond_true ? ctl.tgt_t : ctl.tgt_f;
		dp_op   = cond_true ? ctl.op : OP_NOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			pc_q <= pc_next;
			if (dp_op == OP_FINISH) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	sgl_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.op           (dp_op),
		.operand_a    (operands.operand_a),
		.operand_b    (operands.operand_b),
		.flags        (flags),
		.divisor_out  (results.divisor_out),
		.multiple_out (results.multiple_out),
		.status       (results.status)
	);

	assign results.valid = ov_q;

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		operands.valid && operands.ready |=> pc_q == S_CHKZ)
		else $error("accepted transaction did not start the zero check");

	a_finish_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == S_FINISH |-> !ov_q)
		else $error("result written over a pending result");

	a_error_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status != ST_OK |->
		results.divisor_out == '0 && results.multiple_out == '0)
		else $error("error result carries nonzero values");

	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status == ST_OK |->
		results.divisor_out != '0 && results.multiple_out != '0)
		else $error("ok result carries a zero value");
endmodule

>>> sv/sgl_rom.sv
module sgl_rom (
	input  sgl_pkg::step_t  pc,
	output sgl_pkg::uword_t ctl
);
	import sgl_pkg::*;

	always_comb begin
		unique case (pc)
			S_IDLE:   ctl = '{C_IN_TXN,    OP_LOAD,     S_CHKZ,   S_IDLE};
			S_CHKZ:   ctl = '{C_ZERO,      OP_NOP,      S_OWAIT,  S_HALVE2};
			S_HALVE2: ctl = '{C_BOTH_EVEN, OP_HALVE_XY, S_HALVE2, S_HALVEX};
			S_HALVEX: ctl = '{C_X_EVEN,    OP_HALVE_X,  S_HALVEX, S_HALVEY};
			S_HALVEY: ctl = '{C_Y_EVEN,    OP_HALVE_Y,  S_HALVEY, S_SUB};
			S_SUB:    ctl = '{C_ALWAYS,    OP_SUBSWAP,  S_TESTY,  S_TESTY};
			S_TESTY:  ctl = '{C_Y_NZ,      OP_NOP,      S_HALVEY, S_GSHIFT};
			S_GSHIFT: ctl = '{C_ALWAYS,    OP_DIV_INIT, S_DIV,    S_DIV};
			S_DIV:    ctl = '{C_CNT_RUN,   OP_DIV_STEP, S_DIV,    S_MULI};
			S_MULI:   ctl = '{C_ALWAYS,    OP_MUL_INIT, S_MUL,    S_MUL};
			S_MUL:    ctl = '{C_CNT_RUN,   OP_MUL_STEP, S_MUL,    S_OWAIT};
			S_OWAIT:  ctl = '{C_OUT_FULL,  OP_NOP,      S_OWAIT,  S_FINISH};
			S_FINISH: ctl = '{C_ALWAYS,    OP_FINISH,   S_IDLE,   S_IDLE};
			default:  ctl = '{C_ALWAYS,    OP_NOP,      S_IDLE,   S_IDLE};
		endcase
	end
endmodule

>>> sv/sgl_datapath.sv
module sgl_datapath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  sgl_pkg::op_t                 op,
	input  logic signed [DATA_WIDTH-1:0] operand_a,
	input  logic signed [DATA_WIDTH-1:0] operand_b,
	output sgl_pkg::dp_flags_t           flags,
	output logic        [DATA_WIDTH-2:0] divisor_out,
	output logic signed [DATA_WIDTH-1:0] multiple_out,
	output sgl_pkg::status_t             status
);
	import sgl_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int KW = $clog2(W);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  ma_q, mb_q, x_q, y_q, r_q, q_q;
	logic [KW-1:0] k_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q, zero_q, ovf_q;

	logic [W-1:0]  abs_a, abs_b, rs, msum_add;
	logic          gt, ge;
	logic [W:0]    msum;

	assign abs_a    = operand_a[W-1] ? W'(-operand_a) : W'(operand_a);
	assign abs_b    = operand_b[W-1] ? W'(-operand_b) : W'(operand_b);
	assign gt       = x_q > y_q;
	assign rs       = {r_q[W-2:0], q_q[W-1]};
	assign ge       = rs >= x_q;
	assign msum_add = q_q[W-1] ? mb_q : '0;
	assign msum     = {r_q, 1'b0} + {1'b0, msum_add};

	assign flags.zero      = zero_q;
	assign flags.both_even = !x_q[0] && !y_q[0];
	assign flags.x_even    = !x_q[0];
	assign flags.y_even    = !y_q[0];
	assign flags.y_nz      = y_q != '0;
	assign flags.cnt_run   = cnt_q != CW'(W);

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				ma_q   <= abs_a;
				mb_q   <= abs_b;
				x_q    <= abs_a;
				y_q    <= abs_b;
				k_q    <= '0;
				neg_q  <= operand_a[W-1] || operand_b[W-1];
				zero_q <= (operand_a == '0) || (operand_b == '0);
				ovf_q  <= 1'b0;
			end
			OP_HALVE_XY: begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + 1'b1;
			end
			OP_HALVE_X: x_q <= x_q >> 1;
			OP_HALVE_Y: y_q <= y_q >> 1;
			OP_SUBSWAP: begin
				x_q <= gt ? y_q : x_q;
				y_q <= gt ? x_q - y_q : y_q - x_q;
			end
			OP_DIV_INIT: begin
				x_q   <= x_q << k_q;
				q_q   <= ma_q;
				r_q   <= '0;
				cnt_q <= '0;
			end
			OP_DIV_STEP: begin
				r_q   <= ge ? rs - x_q : rs;
				q_q   <= {q_q[W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_MUL_INIT: begin
				r_q   <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			OP_MUL_STEP: begin
				if (msum[W:W-1] != 2'b00) begin
					ovf_q <= 1'b1;
				end
				r_q   <= msum[W-1:0];
				q_q   <= q_q << 1;
				cnt_q <= cnt_q + 1'b1;
			end
			OP_FINISH: begin
				if (zero_q) begin
					status       <= ST_ZERO;
					divisor_out  <= '0;
					multiple_out <= '0;
				end else if (ovf_q) begin
					status       <= ST_OVF;
					divisor_out  <= '0;
					multiple_out <= '0;
				end else begin
					status       <= ST_OK;
					divisor_out  <= x_q[W-2:0];
					multiple_out <= neg_q ? -$signed(r_q) : $signed(r_q);
				end
			end
			default: begin
			end
		endcase
	end
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import sgl_pkg::*;

	localparam int DW = 32;
	localparam int ITEMS_PER_PHASE = 437;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic [DW-2:0] divisor;
		logic [DW-1:0] multiple;
		status_t       status;
	} gcd_lcm_t;

	class gcd_lcm_scoreboard;
		gcd_lcm_t    pending_results[$];
		int unsigned mismatches;
		int unsigned seen_ok;
		int unsigned seen_zero;
		int unsigned seen_ovf;

		function gcd_lcm_t gcd_lcm_of(logic [DW-1:0] a, logic [DW-1:0] b);
			gcd_lcm_t        r;
			longint unsigned ma, mb, x, y, t, q, l, lim;
			ma = a[DW-1] ? (64'd1 << DW) - {32'd0, a} : {32'd0, a};
			mb = b[DW-1] ? (64'd1 << DW) - {32'd0, b} : {32'd0, b};
			lim = (64'd1 << (DW - 1)) - 1;
			r.divisor = '0;
			r.multiple = '0;
			if (ma == 0 || mb == 0) begin
				r.status = ST_ZERO;
				return r;
			end
			x = ma;
			y = mb;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			q = ma / x;
			if (q > lim / mb) begin
				r.status = ST_OVF;
				return r;
			end
			l = q * mb;
			if (l > lim) begin
				r.status = ST_OVF;
				return r;
			end
			if (a[DW-1] || b[DW-1])
				l = ~l + 1;
			r.divisor = x[DW-2:0];
			r.multiple = l[DW-1:0];
			r.status = ST_OK;
			return r;
		endfunction

		function void note_operands(logic [DW-1:0] a, logic [DW-1:0] b);
			pending_results.push_back(gcd_lcm_of(a, b));
		endfunction

		function void check_result(logic [DW-2:0] d, logic [DW-1:0] m, status_t s);
			gcd_lcm_t e;
			if (pending_results.size() == 0) begin
				$error("unexpected result: divisor %0d multiple %0d status %0d",
					d, $signed(m), s);
				mismatches++;
				return;
			end
			e = pending_results.pop_front();
			case (e.status)
				ST_OK:   seen_ok++;
				ST_ZERO: seen_zero++;
				default: seen_ovf++;
			endcase
			if (d !== e.divisor) begin
				$error("divisor_out: expected %0d, got %0d", e.divisor, d);
				mismatches++;
			end
			if (m !== e.multiple) begin
				$error("multiple_out: expected %0d, got %0d", $signed(e.multiple), $signed(m));
				mismatches++;
			end
			if (s !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, s);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   tx_gap_pct;
	int   rx_stall_pct;
	int   idle_cycles;

	gcd_lcm_scoreboard sb;

	sgl_in_if #(.DATA_WIDTH(DW)) operands ();
	sgl_out_if #(.DATA_WIDTH(DW)) results ();

	signed_gcd_lcm_unit #(.DATA_WIDTH(DW)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operands(operands.sink),
		.results (results.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		results.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (operands.valid === 1'b1 && operands.ready === 1'b1)
				sb.note_operands(operands.operand_a, operands.operand_b);
			if (results.valid === 1'b1 && results.ready === 1'b1)
				sb.check_result(results.divisor_out, results.multiple_out, results.status);
		end
	end

	always @(posedge clk) begin
		if ((operands.valid === 1'b1 && operands.ready === 1'b1) ||
				(results.valid === 1'b1 && results.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: %0d cycles without a transaction", idle_cycles);
			$display("signed_gcd_lcm_unit verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [DW-1:0] apply_sign(logic [DW-1:0] mag);
		return ($urandom_range(1) == 1) ? -mag : mag;
	endfunction

	task automatic send_pair(input logic [DW-1:0] a, input logic [DW-1:0] b);
		while ($urandom_range(99) < tx_gap_pct) begin
			@(negedge clk);
			operands.valid <= 1'b0;
		end
		@(negedge clk);
		operands.valid <= 1'b1;
		operands.operand_a <= a;
		operands.operand_b <= b;
		do
			@(posedge clk);
		while (operands.ready !== 1'b1);
	endtask

	task automatic make_pair(output logic [DW-1:0] a, output logic [DW-1:0] b);
		int unsigned   kind;
		int unsigned   g;
		logic [DW-1:0] corner_vals[5];
		corner_vals = '{32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000, 32'h0000_0001,
			32'hffff_ffff};
		kind = $urandom_range(99);
		if (kind < 40) begin
			a = $urandom_range(1, 65536);
			b = $urandom_range(1, 65536);
		end else if (kind < 65) begin
			g = $urandom_range(1, 1 << $urandom_range(0, 20));
			a = g * $urandom_range(1, 2000);
			b = g * $urandom_range(1, 2000);
		end else if (kind < 75) begin
			a = $urandom_range(1, 50000);
			b = a * $urandom_range(1, 40000);
		end else if (kind < 88) begin
			a = $urandom;
			b = $urandom;
		end else if (kind < 94) begin
			a = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 1000);
			b = 0;
		end else begin
			a = corner_vals[$urandom_range(4)];
			b = ($urandom_range(1) == 1) ? corner_vals[$urandom_range(4)] : $urandom;
		end
		if ($urandom_range(1) == 1) begin
			g = a;
			a = b;
			b = g;
		end
		a = apply_sign(a);
		b = apply_sign(b);
	endtask

	task automatic drain_results();
		@(negedge clk);
		operands.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	logic [DW-1:0] directed_a[22];
	logic [DW-1:0] directed_b[22];

	initial begin
		logic [DW-1:0] a, b;
		directed_a = '{32'd1, 32'hffff_ffff, 32'd0, 32'd5, 32'd0, 32'h7fff_ffff,
			32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001,
			32'h7fff_ffff, 32'd65536, 32'd65536, 32'd12, 32'hffff_fff4, 32'd46341,
			32'd46340, 32'd46341, 32'h4000_0000, 32'h8000_0000, 32'hffff_ffff};
		directed_b = '{32'd1, 32'hffff_ffff, 32'd5, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1,
			32'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'd2, 32'd32768, 32'd65537,
			32'hffff_ffee, 32'hffff_ffee, 32'd46341, 32'd46341, 32'd46342, 32'd2,
			32'h8000_0000, 32'h7fff_ffff};

		sb = new;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		operands.valid = 1'b0;
		operands.operand_a = '0;
		operands.operand_b = '0;
		results.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_gap_pct = 62; rx_stall_pct = 0;  end
				2: begin tx_gap_pct = 0;  rx_stall_pct = 62; end
				default: begin tx_gap_pct = 25; rx_stall_pct = 25; end
			endcase
			if (p == 0) begin
				foreach (directed_a[i])
					send_pair(directed_a[i], directed_b[i]);
				drain_results();
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				make_pair(a, b);
				send_pair(a, b);
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("checked %0d results: %0d ok, %0d zero operand, %0d lcm overflow",
			sb.seen_ok + sb.seen_zero + sb.seen_ovf, sb.seen_ok, sb.seen_zero, sb.seen_ovf);
		$display("corner operands plus random mixes over four sender/receiver stall phases");
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("signed_gcd_lcm_unit verification clean");
		end else begin
			$display("signed_gcd_lcm_unit verification failed");
		end
		$finish;
	end

endmodule

>>> signed_gcd_lcm_unit.f
sv/sgl_pkg.sv
sv/sgl_ifs.sv
sv/sgl_rom.sv
sv/sgl_datapath.sv
sv/signed_gcd_lcm_unit.sv
verif/tb.sv
